// File: design/jrmi_pkg.sv
`timescale 1ns / 1ps

package jrmi_pkg;

  typedef enum logic [1:0] {
    KIND_RST    = 2'd0,
    KIND_TARGET = 2'd1,
    KIND_EOI    = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_OFFSET = 2'd0,
    REG_START_INDEX  = 2'd1,
    REG_TARGET_INDEX = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] RST_FIRST     = 8'hD0;
  localparam logic [7:0] RST_LIMIT     = 8'hD8;
  localparam logic [7:0] EOI_CODE      = 8'hD9;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } scan_status_t;

endpackage

// File: design/jrmi_if.sv
`timescale 1ns / 1ps

interface jrmi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jrmi_result_if
  import jrmi_pkg::*;
#(
  parameter int OFFSET_BITS = 40,
  parameter int INDEX_BITS  = 24
);
  logic                   valid;
  logic                   ready;
  kind_t                  kind;
  logic [INDEX_BITS-1:0]  entry_index;
  logic [OFFSET_BITS-1:0] marker_offset;

  modport source (output valid, output kind, output entry_index, output marker_offset,
                  input ready);
  modport sink (input valid, input kind, input entry_index, input marker_offset,
                output ready);
endinterface

// File: design/jrmi_scan.sv
`timescale 1ns / 1ps

module jrmi_scan
  import jrmi_pkg::*;
#(
  parameter int OFFSET_BITS = 40,
  parameter int INDEX_BITS  = 24,
  parameter int CFG_BITS    = 40
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      accept,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  output scan_status_t              status,
  output logic [INDEX_BITS-1:0]     res_index,
  output logic [OFFSET_BITS-1:0]    res_offset
);

  logic [OFFSET_BITS-1:0] start_offset, start_offset_next;
  logic [INDEX_BITS-1:0]  start_index, start_index_next;
  logic [INDEX_BITS-1:0]  target_index, target_index_next;
  logic                   cfg_hit;

  logic                   after_ff, after_ff_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [INDEX_BITS-1:0]  current_index, current_index_next;
  logic                   finished, finished_next;

  always_comb begin
    start_offset_next = start_offset;
    start_index_next  = start_index;
    target_index_next = target_index;
    cfg_hit           = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_OFFSET: begin
          start_offset_next = cfg_data[OFFSET_BITS-1:0];
          cfg_hit           = 1'b1;
        end
        REG_START_INDEX: begin
          start_index_next = cfg_data[INDEX_BITS-1:0];
          cfg_hit          = 1'b1;
        end
        REG_TARGET_INDEX: begin
          target_index_next = cfg_data[INDEX_BITS-1:0];
          cfg_hit           = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [INDEX_BITS-1:0]  idx_inc;
    logic                   is_rst;
    logic                   handled;
    pos_inc            = byte_position + OFFSET_BITS'(1);
    idx_inc            = current_index + INDEX_BITS'(1);
    is_rst             = (data_byte >= RST_FIRST) && (data_byte < RST_LIMIT);
    handled            = 1'b0;
    after_ff_next      = after_ff;
    byte_position_next = byte_position;
    current_index_next = current_index;
    finished_next      = finished;
    status             = '{valid: 1'b0, kind: KIND_END};
    res_index          = current_index;
    res_offset         = pos_inc;
    if (accept && !finished) begin
      if (current_index >= target_index) begin
        // The target was met before this byte: the byte itself is not consumed.
        finished_next = 1'b1;
        status        = '{valid: 1'b1, kind: KIND_TARGET};
        res_offset    = byte_position;
      end else begin
        byte_position_next = pos_inc;
        if (after_ff) begin
          after_ff_next = 1'b0;
          if (data_byte == EOI_CODE) begin
            finished_next = 1'b1;
            status        = '{valid: 1'b1, kind: KIND_EOI};
            handled       = 1'b1;
          end else if (is_rst) begin
            current_index_next = idx_inc;
            res_index          = idx_inc;
            if (idx_inc == target_index) begin
              finished_next = 1'b1;
              status        = '{valid: 1'b1, kind: KIND_TARGET};
              handled       = 1'b1;
            end else if (!last_byte) begin
              status  = '{valid: 1'b1, kind: KIND_RST};
              handled = 1'b1;
            end
          end
        end else if (data_byte == MARKER_PREFIX) begin
          after_ff_next = 1'b1;
        end
        if (last_byte && !handled) begin
          finished_next = 1'b1;
          after_ff_next = 1'b0;
          status        = '{valid: 1'b1, kind: KIND_END};
          res_index     = current_index_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset  <= '0;
      start_index   <= '0;
      target_index  <= INDEX_BITS'(1);
      after_ff      <= 1'b0;
      byte_position <= '0;
      current_index <= '0;
      finished      <= 1'b0;
    end else begin
      start_offset <= start_offset_next;
      start_index  <= start_index_next;
      target_index <= target_index_next;
      if (cfg_hit) begin
        after_ff      <= 1'b0;
        byte_position <= start_offset_next;
        current_index <= start_index_next;
        finished      <= 1'b0;
      end else begin
        after_ff      <= after_ff_next;
        byte_position <= byte_position_next;
        current_index <= current_index_next;
        finished      <= finished_next;
      end
    end
  end

endmodule

// File: design/jrmi_out_stage.sv
`timescale 1ns / 1ps

module jrmi_out_stage
  import jrmi_pkg::*;
#(
  parameter int OFFSET_BITS = 40,
  parameter int INDEX_BITS  = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  kind_t                  load_kind,
  input  logic [INDEX_BITS-1:0]  load_index,
  input  logic [OFFSET_BITS-1:0] load_offset,
  input  logic                   out_ready,
  output logic                   slot_free,
  output logic                   out_valid,
  output kind_t                  out_kind,
  output logic [INDEX_BITS-1:0]  out_index,
  output logic [OFFSET_BITS-1:0] out_offset
);

  logic out_valid_next;

  assign slot_free = !rst && (!out_valid || out_ready);

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= load_kind;
      out_index  <= load_index;
      out_offset <= load_offset;
    end
  end

endmodule

// File: design/jpeg_restart_marker_indexer.sv
// Channel     Direction  Payload                                  Handshake
// byte_in     in         data_byte[7:0], last_byte                valid / ready
// result_out  out        kind[1:0], entry_index, marker_offset    valid / ready
// cfg         in         cfg_index, cfg_data                      cfg_wr_en, no wait
//
// One byte is taken every clock while the output register is free or being
// read; its result, if any, appears in that register on the following cycle.
// The scan logic sits between the input port and that register. Bytes are also
// refused in reset. Reset and a write to a defined cfg_index restart the scan.
`timescale 1ns / 1ps

module jpeg_restart_marker_indexer
  import jrmi_pkg::*;
#(
  parameter int OFFSET_BITS = 40,
  parameter int INDEX_BITS  = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((OFFSET_BITS > INDEX_BITS) ? OFFSET_BITS : INDEX_BITS)-1:0] cfg_data,
  jrmi_byte_if.sink                 byte_in,
  jrmi_result_if.source             result_out
);

  localparam int CFG_BITS = (OFFSET_BITS > INDEX_BITS) ? OFFSET_BITS : INDEX_BITS;

  logic                   accept;
  logic                   slot_free;
  scan_status_t           status;
  logic [INDEX_BITS-1:0]  res_index;
  logic [OFFSET_BITS-1:0] res_offset;

  assign byte_in.ready = slot_free;
  assign accept        = byte_in.valid && slot_free;

  jrmi_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .INDEX_BITS (INDEX_BITS),
    .CFG_BITS   (CFG_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (byte_in.data_byte),
    .last_byte (byte_in.last_byte),
    .status    (status),
    .res_index (res_index),
    .res_offset(res_offset)
  );

  jrmi_out_stage #(
    .OFFSET_BITS(OFFSET_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && status.valid),
    .load_kind  (status.kind),
    .load_index (res_index),
    .load_offset(res_offset),
    .out_ready  (result_out.ready),
    .slot_free  (slot_free),
    .out_valid  (result_out.valid),
    .out_kind   (result_out.kind),
    .out_index  (result_out.entry_index),
    .out_offset (result_out.marker_offset)
  );

endmodule

// File: design/jrmi_checker.sv
`timescale 1ns / 1ps

module jrmi_checker
  import jrmi_pkg::*;
#(
  parameter int OFFSET_BITS = 40,
  parameter int INDEX_BITS  = 24
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input kind_t                  out_kind,
  input logic [INDEX_BITS-1:0]  out_index,
  input logic [OFFSET_BITS-1:0] out_offset
);

  // A result held back by the sink stays put with its contents unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_index)
      && $stable(out_offset))
  else $error("stalled result changed or vanished");

  // Bytes are only refused while a result is waiting.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
  else $error("input stalled with an empty output register");

  // A restart marker needs two further bytes, so restart results never follow back to back.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_kind == KIND_RST |=> !(out_valid && out_kind == KIND_RST))
  else $error("restart results delivered in consecutive cycles");

  // A finishing result leaves nothing behind it in the output register.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_kind != KIND_RST |=> !out_valid)
  else $error("result delivered after the scan finished");

endmodule

bind jpeg_restart_marker_indexer jrmi_checker #(
  .OFFSET_BITS(OFFSET_BITS),
  .INDEX_BITS (INDEX_BITS)
) u_jrmi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (byte_in.ready),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_kind  (result_out.kind),
  .out_index (result_out.entry_index),
  .out_offset(result_out.marker_offset)
);
